// ===== src/salwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package salwc_pkg;

   localparam int SETS      = 64;
   localparam int WAYS      = 4;
   localparam int ADDR_BITS = 32;

   localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TAG_WIDTH = 32;
   localparam int AGE_BITS  = 2;

   localparam int OFFSET_CFG_BITS = 4;
   localparam int INDEX_CFG_BITS  = 3;
   localparam int WAYS_CFG_BITS   = 3;
   localparam int CSR_DATA_BITS   = 4;
   localparam int CSR_ADDR_BITS   = 2;

   localparam logic [OFFSET_CFG_BITS-1:0] OFFSET_BITS_MAX   = 4'd8;
   localparam logic [INDEX_CFG_BITS-1:0]  INDEX_BITS_MAX    = 3'd6;
   localparam logic [OFFSET_CFG_BITS-1:0] OFFSET_BITS_RESET = 4'd5;
   localparam logic [INDEX_CFG_BITS-1:0]  INDEX_BITS_RESET  = 3'd6;
   localparam logic [WAYS_CFG_BITS-1:0]   WAYS_RESET        = 3'd4;
   localparam logic [AGE_BITS-1:0]        AGE_MAX           = 2'd3;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_OFFSET_BITS = 2'd0,
      CSR_INDEX_BITS  = 2'd1,
      CSR_WAYS_IN_USE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                 kind;
      logic [ADDR_BITS-1:0] address;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [1:0]           way;
      logic                 write_back;
      logic [TAG_WIDTH-1:0] victim_tag;
   } rsp_type;

   typedef struct packed {
      logic [WAYS-1:0]                valid;
      logic [WAYS-1:0]                dirty;
      logic [WAYS-1:0][AGE_BITS-1:0]  age;
      logic [WAYS-1:0][TAG_WIDTH-1:0] tag;
   } row_type;

endpackage

`default_nettype wire

// ===== src/set_assoc_lru_writeback_cache_tags_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tag and replacement engine of a set-associative write-back, write-allocate cache
// with true LRU ages per way. One access is taken in every cycle in which start is
// high and busy is low; busy is high only during reset. Its result appears on the
// rsp_ ports with rsp_strobe for exactly one cycle, after the s1 stage registers and the rsp
// output registers, and must be captured in that cycle because the result side cannot stall. The rate of
// one access per cycle is set by the single registered read of the set memory, one
// row of all ways per set, with the row just written forwarded to the next access.
// Set state starts out invalid right after reset without a clearing pass. Write the
// configuration registers only while no access is in flight.
module set_assoc_lru_writeback_cache_tags_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire salwc_pkg::req_type                     req_payload,
   output logic                                        rsp_strobe,
   output salwc_pkg::rsp_type                          rsp_payload,
   input  wire logic                                   csr_write_enable,
   input  wire logic [salwc_pkg::CSR_ADDR_BITS-1:0]    csr_index,
   input  wire logic [salwc_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import salwc_pkg::*;

   logic [OFFSET_CFG_BITS-1:0] offset_bits_ff;
   logic [INDEX_CFG_BITS-1:0]  index_bits_ff;
   logic [WAYS_CFG_BITS-1:0]   ways_in_use_ff;

   logic [OFFSET_CFG_BITS-1:0] ob;
   logic [INDEX_CFG_BITS-1:0]  ib;
   logic [WAYS_CFG_BITS-1:0]   nw;
   logic [ADDR_BITS-1:0]       index_field;
   logic [ADDR_BITS-1:0]       set_mask;
   logic [SET_BITS-1:0]        req_set;
   logic [TAG_WIDTH-1:0]       req_tag;
   logic                       accept;

   row_type             row_mem [SETS];
   row_type             mem_q_ff;
   logic [SETS-1:0]     row_valid_ff;

   logic                 s1_valid_ff;
   logic                 s1_write_ff;
   logic [SET_BITS-1:0]  s1_set_ff;
   logic [TAG_WIDTH-1:0] s1_tag_ff;

   logic                fwd_valid_ff;
   logic [SET_BITS-1:0] fwd_set_ff;
   row_type             fwd_row_ff;

   row_type             cur_row;
   row_type             new_row_in;
   logic [WAYS-1:0]     way_en;
   logic [WAYS-1:0]     match;
   logic                hit;
   logic                found;
   logic [WAY_BITS-1:0] hit_way;
   logic [WAY_BITS-1:0] inv_way;
   logic [WAY_BITS-1:0] old_way;
   logic [AGE_BITS-1:0] best_age;
   logic [WAY_BITS-1:0] sel;
   rsp_type             rsp_in;

   logic                rsp_strobe_ff;
   rsp_type             rsp_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      ob = (offset_bits_ff > OFFSET_BITS_MAX) ? OFFSET_BITS_MAX : offset_bits_ff;
      ib = (index_bits_ff > INDEX_BITS_MAX) ? INDEX_BITS_MAX : index_bits_ff;
      if (ways_in_use_ff == '0) begin
         nw = WAYS_CFG_BITS'(1);
      end else if (ways_in_use_ff > WAYS_CFG_BITS'(WAYS)) begin
         nw = WAYS_CFG_BITS'(WAYS);
      end else begin
         nw = ways_in_use_ff;
      end
      index_field = req_payload.address >> ob;
      set_mask    = ~({ADDR_BITS{1'b1}} << ib);
      req_set     = SET_BITS'(index_field & set_mask);
      req_tag     = TAG_WIDTH'(req_payload.address >> ({1'b0, ob} + 5'(ib)));
   end

   always_ff @(posedge clock) begin
      mem_q_ff <= row_mem[req_set];
      if (s1_valid_ff) begin
         row_mem[s1_set_ff] <= new_row_in;
      end
   end

   always_comb begin
      if (fwd_valid_ff && fwd_set_ff == s1_set_ff) begin
         cur_row = fwd_row_ff;
      end else if (row_valid_ff[s1_set_ff]) begin
         cur_row = mem_q_ff;
      end else begin
         cur_row = '0;
      end

      for (int w = 0; w < WAYS; w++) begin
         way_en[w] = w < int'(nw);
         match[w]  = way_en[w] && cur_row.valid[w] && cur_row.tag[w] == s1_tag_ff;
      end

      hit     = 1'b0;
      hit_way = '0;
      found   = 1'b0;
      inv_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit     = 1'b1;
            hit_way = WAY_BITS'(w);
         end
         if (way_en[w] && !cur_row.valid[w]) begin
            found   = 1'b1;
            inv_way = WAY_BITS'(w);
         end
      end

      best_age = cur_row.age[0];
      old_way  = '0;
      for (int w = 1; w < WAYS; w++) begin
         if (way_en[w] && cur_row.age[w] > best_age) begin
            best_age = cur_row.age[w];
            old_way  = WAY_BITS'(w);
         end
      end

      if (hit) begin
         sel = hit_way;
      end else if (found) begin
         sel = inv_way;
      end else begin
         sel = old_way;
      end

      new_row_in = cur_row;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_BITS'(w) != sel && way_en[w] && cur_row.valid[w]) begin
            if (hit ? (cur_row.age[w] < cur_row.age[sel]) : (cur_row.age[w] < AGE_MAX)) begin
               new_row_in.age[w] = cur_row.age[w] + AGE_BITS'(1);
            end
         end
      end
      new_row_in.age[sel] = '0;
      if (hit) begin
         new_row_in.dirty[sel] = cur_row.dirty[sel] | s1_write_ff;
      end else begin
         new_row_in.tag[sel]   = s1_tag_ff;
         new_row_in.valid[sel] = 1'b1;
         new_row_in.dirty[sel] = s1_write_ff;
      end

      rsp_in.hit        = hit;
      rsp_in.way        = 2'(sel);
      rsp_in.write_back = !hit && !found && cur_row.dirty[sel];
      rsp_in.victim_tag = (!hit && !found) ? cur_row.tag[sel] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OFFSET_BITS_RESET;
         index_bits_ff  <= INDEX_BITS_RESET;
         ways_in_use_ff <= WAYS_RESET;
         row_valid_ff   <= '0;
         s1_valid_ff    <= 1'b0;
         fwd_valid_ff   <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_OFFSET_BITS: offset_bits_ff <= OFFSET_CFG_BITS'(csr_write_data);
               CSR_INDEX_BITS:  index_bits_ff  <= INDEX_CFG_BITS'(csr_write_data);
               CSR_WAYS_IN_USE: ways_in_use_ff <= WAYS_CFG_BITS'(csr_write_data);
               default: begin
               end
            endcase
         end
         s1_valid_ff   <= accept;
         rsp_strobe_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            row_valid_ff[s1_set_ff] <= 1'b1;
            fwd_valid_ff            <= 1'b1;
         end
      end
      if (accept) begin
         s1_write_ff <= req_payload.kind;
         s1_set_ff   <= req_set;
         s1_tag_ff   <= req_tag;
      end
      if (s1_valid_ff) begin
         fwd_set_ff <= s1_set_ff;
         fwd_row_ff <= new_row_in;
         rsp_ff     <= rsp_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_hit_no_eviction: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.hit |-> !rsp_payload.write_back && rsp_payload.victim_tag == '0)
      else $error("hit reported together with an eviction");

   a_item_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_strobe)
      else $error("accepted item produced no result two cycles later");

   a_forward_tracks_write: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> fwd_valid_ff && fwd_set_ff == $past(s1_set_ff)
                      && row_valid_ff[$past(s1_set_ff)])
      else $error("forwarded row does not follow the last set update");

   a_written_row_has_line: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_ff |-> fwd_row_ff.valid != '0)
      else $error("updated set holds no valid line");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import salwc_pkg::*;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int DRAIN_LIMIT    = 64;
   localparam int LINE_COUNT     = SETS * WAYS;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   req_type                  req_payload;
   logic                     rsp_strobe;
   rsp_type                  rsp_payload;
   logic                     csr_write_enable;
   logic [CSR_ADDR_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   set_assoc_lru_writeback_cache_tags_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_payload      (req_payload),
      .rsp_strobe       (rsp_strobe),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   logic [TAG_WIDTH-1:0] way_tag   [LINE_COUNT];
   logic                 way_valid [LINE_COUNT];
   logic                 way_dirty [LINE_COUNT];
   logic [AGE_BITS-1:0]  way_age   [LINE_COUNT];

   logic [OFFSET_CFG_BITS-1:0] shadow_offset;
   logic [INDEX_CFG_BITS-1:0]  shadow_index;
   logic [WAYS_CFG_BITS-1:0]   shadow_ways;

   rsp_type     expected_lookups [$];
   rsp_type     oldest_lookup;
   int          errors;
   int          burst_left;
   bit          use_gaps;
   logic [31:0] tag_pool [8];
   int          pool_span;
   int          set_span;
   int          stalled_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
   endtask

   function automatic void lookup_geometry(output int unsigned ob, output int unsigned ib,
                                           output int unsigned nw);
      ob = (shadow_offset > OFFSET_BITS_MAX) ? 32'(OFFSET_BITS_MAX) : 32'(shadow_offset);
      ib = (shadow_index > INDEX_BITS_MAX) ? 32'(INDEX_BITS_MAX) : 32'(shadow_index);
      nw = (shadow_ways == 0) ? 1 : ((shadow_ways > WAYS) ? WAYS : 32'(shadow_ways));
   endfunction

   function automatic logic [31:0] compose_address(logic [31:0] tag, logic [31:0] set_no,
                                                    logic [31:0] offset);
      int unsigned ob, ib, nw;
      lookup_geometry(ob, ib, nw);
      return (tag << (ob + ib)) | ((set_no & ((32'd1 << ib) - 1)) << ob)
             | (offset & ((32'd1 << ob) - 1));
   endfunction

   // Updates the tag, age and dirty state of the set and returns the lookup result.
   function automatic rsp_type predict_lookup(req_type item);
      int unsigned ob, ib, nw, set_no, base, sel, best, w;
      logic [TAG_WIDTH-1:0] tag;
      logic [AGE_BITS-1:0] old_age;
      logic hit, found;
      rsp_type res;
      lookup_geometry(ob, ib, nw);
      set_no = ((item.address >> ob) & ((32'd1 << ib) - 1)) % SETS;
      tag = item.address >> (ob + ib);
      base = set_no * WAYS;
      hit = 1'b0;
      found = 1'b0;
      sel = 0;
      res = '0;
      for (w = 0; w < nw; w++) begin
         if (!hit && way_valid[base + w] && way_tag[base + w] == tag) begin
            hit = 1'b1;
            sel = w;
         end
      end
      if (hit) begin
         old_age = way_age[base + sel];
         for (w = 0; w < nw; w++) begin
            if (w != sel && way_valid[base + w] && way_age[base + w] < old_age) begin
               way_age[base + w]++;
            end
         end
         way_age[base + sel] = '0;
         if (item.kind) begin
            way_dirty[base + sel] = 1'b1;
         end
      end else begin
         for (w = 0; w < nw; w++) begin
            if (!found && !way_valid[base + w]) begin
               found = 1'b1;
               sel = w;
            end
         end
         if (!found) begin
            best = 0;
            sel = 0;
            for (w = 0; w < nw; w++) begin
               if (w == 0 || way_age[base + w] > best) begin
                  best = 32'(way_age[base + w]);
                  sel = w;
               end
            end
            res.write_back = way_dirty[base + sel];
            res.victim_tag = way_tag[base + sel];
         end
         for (w = 0; w < nw; w++) begin
            if (w != sel && way_valid[base + w] && way_age[base + w] < AGE_MAX) begin
               way_age[base + w]++;
            end
         end
         way_tag[base + sel] = tag;
         way_valid[base + sel] = 1'b1;
         way_dirty[base + sel] = item.kind;
         way_age[base + sel] = '0;
      end
      res.hit = hit;
      res.way = sel[1:0];
      return res;
   endfunction

   task automatic send_access(logic kind, logic [31:0] address);
      int gap;
      req_type item;
      item.kind = kind;
      item.address = address;
      if (burst_left == 0) begin
         gap = use_gaps ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      start = 1'b1;
      req_payload = item;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_lookups.push_back(predict_lookup(item));
   endtask

   task automatic drain_lookups();
      int waited;
      @(negedge clock);
      start = 1'b0;
      burst_left = 0;
      waited = 0;
      while (expected_lookups.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (3) @(posedge clock);
      if (expected_lookups.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_lookups.size()));
         expected_lookups.delete();
      end
   endtask

   task automatic write_reg(logic [CSR_ADDR_BITS-1:0] reg_index, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = reg_index;
      csr_write_data = value;
      @(posedge clock);
      case (reg_index)
         CSR_OFFSET_BITS: shadow_offset = value;
         CSR_INDEX_BITS:  shadow_index = value[INDEX_CFG_BITS-1:0];
         CSR_WAYS_IN_USE: shadow_ways = value[WAYS_CFG_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic refresh_tag_pool();
      for (int i = 0; i < 8; i++) begin
         tag_pool[i] = (i == 0) ? 32'd0 : $urandom;
      end
      pool_span = $urandom_range(1, 7);
      set_span = $urandom_range(0, 3);
   endtask

   task automatic set_config(logic [CSR_DATA_BITS-1:0] offset_bits,
                             logic [CSR_DATA_BITS-1:0] index_bits,
                             logic [CSR_DATA_BITS-1:0] ways);
      drain_lookups();
      write_reg(CSR_OFFSET_BITS, offset_bits);
      write_reg(CSR_INDEX_BITS, index_bits);
      write_reg(CSR_WAYS_IN_USE, ways);
      refresh_tag_pool();
   endtask

   // Most accesses reuse a few tags in a few sets so that hits, fills and evictions mix.
   task automatic send_random_items(int count);
      logic [31:0] address;
      repeat (count) begin
         if ($urandom_range(0, 9) < 2) begin
            address = $urandom;
         end else begin
            address = compose_address(tag_pool[$urandom_range(0, pool_span)],
                                      $urandom_range(0, set_span), $urandom);
         end
         send_access(1'($urandom_range(0, 1)), address);
      end
   endtask

   task automatic test_directed();
      use_gaps = 1'b1;
      send_access(KIND_READ, compose_address(0, 0, 0));
      send_access(KIND_WRITE, compose_address(1, 0, 0));
      send_access(KIND_READ, compose_address(2, 0, 0));
      send_access(KIND_READ, compose_address(3, 0, 0));
      send_access(KIND_READ, compose_address(0, 0, 0));
      send_access(KIND_WRITE, compose_address(2, 0, 7));
      send_access(KIND_READ, compose_address(4, 0, 0));
      send_access(KIND_READ, compose_address(5, 0, 0));
      send_access(KIND_WRITE, compose_address(6, 0, 0));
      send_access(KIND_READ, compose_address(7, 0, 0));
      send_access(KIND_READ, compose_address(8, 0, 0));
      send_access(KIND_READ, compose_address(9, 0, 0));
      send_access(KIND_READ, 32'hFFFF_FFFF);
      send_access(KIND_WRITE, 32'hFFFF_FFFF);
      send_access(KIND_WRITE, 32'h8000_0000);
      send_access(KIND_READ, 32'hFFFF_FFE0);
      send_access(KIND_WRITE, 32'h0000_001F);
   endtask

   task automatic test_config_extremes();
      use_gaps = 1'b1;
      set_config(4'd0, 4'd0, 4'd1);
      send_access(KIND_WRITE, compose_address(1, 0, 0));
      send_access(KIND_READ, compose_address(2, 0, 0));
      send_access(KIND_READ, compose_address(2, 0, 0));
      send_access(KIND_WRITE, compose_address(3, 0, 0));
      send_random_items(40);
      set_config(4'd15, 4'd7, 4'd0);
      send_random_items(40);
      set_config(OFFSET_BITS_MAX, 4'(INDEX_BITS_MAX), 4'd7);
      send_random_items(40);
      set_config(4'd0, 4'd6, 4'd1);
      send_random_items(30);
      set_config(4'd0, 4'd6, 4'd4);
      send_random_items(30);
      drain_lookups();
      write_reg(CSR_UNUSED, 4'hF);
      send_random_items(20);
   endtask

   task automatic test_random_phases();
      repeat (8) begin
         if ($urandom_range(0, 3) == 0) begin
            set_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 7)),
                       4'($urandom_range(0, 7)));
         end else begin
            set_config(4'($urandom_range(0, 8)), 4'($urandom_range(0, 6)),
                       4'($urandom_range(1, 4)));
         end
         use_gaps = ($urandom_range(0, 2) != 0);
         send_random_items(110);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_lookups.size() == 0) begin
            report_mismatch($sformatf("unexpected result hit=%b way=%0d wb=%b tag=%h",
                            rsp_payload.hit, rsp_payload.way, rsp_payload.write_back,
                            rsp_payload.victim_tag));
         end else begin
            oldest_lookup = expected_lookups.pop_front();
            if (rsp_payload.hit !== oldest_lookup.hit)
               report_mismatch($sformatf("hit %b, wanted %b", rsp_payload.hit,
                               oldest_lookup.hit));
            if (rsp_payload.way !== oldest_lookup.way)
               report_mismatch($sformatf("way %0d, wanted %0d", rsp_payload.way,
                               oldest_lookup.way));
            if (rsp_payload.write_back !== oldest_lookup.write_back)
               report_mismatch($sformatf("write_back %b, wanted %b", rsp_payload.write_back,
                               oldest_lookup.write_back));
            if (rsp_payload.victim_tag !== oldest_lookup.victim_tag)
               report_mismatch($sformatf("victim_tag %h, wanted %h", rsp_payload.victim_tag,
                               oldest_lookup.victim_tag));
         end
      end
   end

   initial begin
      stalled_cycles = 0;
      while (stalled_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles++;
         end
      end
      $display("FAIL set_assoc_lru_writeback_cache_tags_core");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      errors = 0;
      burst_left = 0;
      use_gaps = 1'b1;
      for (int i = 0; i < LINE_COUNT; i++) begin
         way_tag[i] = '0;
         way_valid[i] = 1'b0;
         way_dirty[i] = 1'b0;
         way_age[i] = '0;
      end
      shadow_offset = OFFSET_BITS_RESET;
      shadow_index = INDEX_BITS_RESET;
      shadow_ways = WAYS_RESET;
      refresh_tag_pool();
      repeat (12) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_config_extremes();
      test_random_phases();
      drain_lookups();
      if (errors == 0) begin
         $display("PASS set_assoc_lru_writeback_cache_tags_core");
      end else begin
         $display("FAIL set_assoc_lru_writeback_cache_tags_core");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/salwc_pkg.sv
src/set_assoc_lru_writeback_cache_tags_core.sv
dv/testbench.sv
